### rtl/tsa_pkg.sv
// Shared constants and types for the scratchpad-to-text block.
package tsa_pkg;

    localparam int TEXT_SLOTS = 12;
    localparam int IDX_W      = $clog2(TEXT_SLOTS);
    localparam int LEN_W      = $clog2(TEXT_SLOTS + 1);

    localparam logic [7:0] CRC_POLY   = 8'h8C;
    localparam logic [3:0] CRC_BYTE   = 4'd8;
    localparam logic [3:0] CRC_STEPS  = 4'd8;
    localparam logic [1:0] RES_RESET  = 2'd3;
    localparam logic [1:0] RES_MAX    = 2'd3;

    localparam logic [6:0] HUNDRED    = 7'd100;
    localparam logic [6:0] TEN        = 7'd10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    localparam logic [1:0] STATUS_NEW     = 2'd0;
    localparam logic [1:0] STATUS_SAME    = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

    typedef struct packed {
        logic start;
        logic clear;
    } crc_ctrl_t;

endpackage

### rtl/tsa_crc.sv
// Bit-serial 1-Wire CRC-8 unit that folds in one byte a bit at a time.
module tsa_crc (
    input  logic              clk,
    input  logic              rst_n,
    input  tsa_pkg::crc_ctrl_t ctrl,
    input  logic [7:0]        data,
    output logic              busy,
    output logic [7:0]        crc
);
    import tsa_pkg::*;

    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;

    always_comb
    begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (ctrl.clear)
        begin
            crc_next = 8'd0;
            cnt_next = 4'd0;
        end
        else if (ctrl.start)
        begin
            crc_next = crc_reg ^ data;
            cnt_next = CRC_STEPS;
        end
        else if (cnt_reg != 4'd0)
        begin
            if (crc_reg[0])
                crc_next = (crc_reg >> 1) ^ CRC_POLY;
            else
                crc_next = crc_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= 8'd0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy = (cnt_reg != 4'd0);
    assign crc  = crc_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> cnt_reg == 4'd0)
        else $error("CRC unit started while shifting.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CRC_STEPS)
        else $error("CRC step count out of range.");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.start && !ctrl.clear) |=> cnt_reg == CRC_STEPS)
        else $error("CRC unit did not load its step count.");

endmodule

### rtl/temp_scratchpad_to_ascii_top.sv
// Top level: byte sequencer, text builder, text store and output register.
// Bytes 0 to 7 stall the input while the CRC unit shifts one bit per cycle.
// After byte 8 a new reading is rebuilt as text digit by digit through subtract and
// shift-add steps; a mark of an unchanged or bad reading is written on acceptance.
// The stored text then leaves at one character per cycle while out_stall is low, up to 11 characters.
// Reset (rst_n low, asynchronous) clears control state; nothing is emitted before a text.
module temp_scratchpad_to_ascii_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scratch_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] text_char,
    output logic       last_char,
    output logic [1:0] status
);
    import tsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CRC, S_SIGN, S_HUND, S_TENS, S_ONES,
        S_DOT, S_FRAC, S_SPACE, S_NL, S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        res_reg, res_next;
    logic [3:0]        byte_idx_reg, byte_idx_next;
    logic [15:0]       raw_reg, raw_next;
    logic [15:0]       prev_reg, prev_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  rd_reg, rd_next;
    logic              neg_reg, neg_next;
    logic [6:0]        whole_reg, whole_next;
    logic [3:0]        frac_reg, frac_next;
    logic [3:0]        tcnt_reg, tcnt_next;
    logic              hund_reg, hund_next;
    logic [1:0]        stat_reg, stat_next;
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        ochar_reg, ochar_next;
    logic              olast_reg, olast_next;
    logic [1:0]        ostat_reg, ostat_next;

    logic [7:0]        store_mem [TEXT_SLOTS];
    logic              store_we;
    logic [IDX_W-1:0]  store_addr;
    logic [7:0]        store_wdata;

    crc_ctrl_t         crc_ctrl;
    logic              crc_busy;
    logic [7:0]        crc_val;

    logic              in_acc;
    logic              out_load;
    logic              put;
    logic [7:0]        put_char;
    logic [15:0]       mag;
    logic [2:0]        fbits;
    logic [3:0]        fmask;
    logic [7:0]        f10;
    logic [7:0]        fdigit;
    logic [LEN_W-1:0]  len_m1;

    tsa_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (scratch_byte),
        .busy  (crc_busy),
        .crc   (crc_val)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_load = (state_reg == S_EMIT) && (!ovalid_reg || !out_stall);
    assign len_m1   = len_reg - LEN_W'(1);

    assign mag    = raw_reg[15] ? (16'd0 - raw_reg) : raw_reg;
    assign fbits  = {1'b0, res_reg} + 3'd1;
    assign fmask  = ~(4'hF << fbits);
    assign f10    = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0};
    assign fdigit = f10 >> fbits;

    always_comb
    begin
        state_next    = state_reg;
        res_next      = res_reg;
        byte_idx_next = byte_idx_reg;
        raw_next      = raw_reg;
        prev_next     = prev_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        rd_next       = rd_reg;
        neg_next      = neg_reg;
        whole_next    = whole_reg;
        frac_next     = frac_reg;
        tcnt_next     = tcnt_reg;
        hund_next     = hund_reg;
        stat_next     = stat_reg;
        ovalid_next   = ovalid_reg;
        ochar_next    = ochar_reg;
        olast_next    = olast_reg;
        ostat_next    = ostat_reg;
        crc_ctrl      = '0;
        put           = 1'b0;
        put_char      = CHAR_SPACE;
        store_we      = 1'b0;
        store_addr    = pos_reg[IDX_W-1:0];
        store_wdata   = put_char;

        if (cfg_we)
            res_next = cfg_data & RES_MAX;

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (byte_idx_reg < CRC_BYTE)
                    begin
                        if (byte_idx_reg == 4'd0)
                            raw_next = {raw_reg[15:8], scratch_byte};
                        else if (byte_idx_reg == 4'd1)
                            raw_next = {scratch_byte, raw_reg[7:0]};
                        crc_ctrl.start = 1'b1;
                        byte_idx_next  = byte_idx_reg + 4'd1;
                        state_next     = S_CRC;
                    end
                    else
                    begin
                        byte_idx_next  = 4'd0;
                        crc_ctrl.clear = 1'b1;
                        rd_next        = '0;
                        if (crc_val == scratch_byte && raw_reg != prev_reg)
                        begin
                            prev_next  = raw_reg;
                            stat_next  = STATUS_NEW;
                            neg_next   = raw_reg[15];
                            whole_next = mag[10:4];
                            frac_next  = mag[3:0] >> (RES_MAX - res_reg);
                            pos_next   = '0;
                            tcnt_next  = 4'd0;
                            hund_next  = 1'b0;
                            state_next = S_SIGN;
                        end
                        else
                        begin
                            stat_next = (crc_val == scratch_byte) ? STATUS_SAME
                                                                  : STATUS_BAD_CRC;
                            if (len_reg >= LEN_W'(2) && len_reg <= LEN_W'(TEXT_SLOTS))
                            begin
                                store_we    = 1'b1;
                                store_addr  = IDX_W'(len_reg - LEN_W'(2));
                                store_wdata = (crc_val == scratch_byte) ? CHAR_SPACE
                                                                        : CHAR_STAR;
                            end
                            if (len_reg != '0)
                                state_next = S_EMIT;
                        end
                    end
                end
            end
            S_CRC:
            begin
                if (!crc_busy)
                    state_next = S_IDLE;
            end
            S_SIGN:
            begin
                put        = neg_reg;
                put_char   = CHAR_MINUS;
                state_next = S_HUND;
            end
            S_HUND:
            begin
                if (whole_reg >= HUNDRED)
                begin
                    put        = 1'b1;
                    put_char   = CHAR_ZERO + 8'd1;
                    whole_next = whole_reg - HUNDRED;
                    hund_next  = 1'b1;
                end
                state_next = S_TENS;
            end
            S_TENS:
            begin
                if (whole_reg >= TEN)
                begin
                    whole_next = whole_reg - TEN;
                    tcnt_next  = tcnt_reg + 4'd1;
                end
                else
                begin
                    put        = hund_reg || (tcnt_reg != 4'd0);
                    put_char   = CHAR_ZERO + {4'd0, tcnt_reg};
                    state_next = S_ONES;
                end
            end
            S_ONES:
            begin
                put        = 1'b1;
                put_char   = CHAR_ZERO + {1'b0, whole_reg};
                state_next = S_DOT;
            end
            S_DOT:
            begin
                put        = 1'b1;
                put_char   = CHAR_DOT;
                state_next = S_FRAC;
            end
            S_FRAC:
            begin
                if (frac_reg != 4'd0)
                begin
                    put       = 1'b1;
                    put_char  = CHAR_ZERO + fdigit;
                    frac_next = f10[3:0] & fmask;
                end
                else
                    state_next = S_SPACE;
            end
            S_SPACE:
            begin
                put        = 1'b1;
                put_char   = CHAR_SPACE;
                state_next = S_NL;
            end
            S_NL:
            begin
                put        = 1'b1;
                put_char   = CHAR_NL;
                state_next = S_EMIT;
                if (pos_reg < LEN_W'(TEXT_SLOTS))
                    len_next = pos_reg + LEN_W'(1);
                else
                    len_next = pos_reg;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = store_mem[rd_reg[IDX_W-1:0]];
                    olast_next  = (rd_reg == len_m1);
                    ostat_next  = stat_reg;
                    rd_next     = rd_reg + LEN_W'(1);
                    if (rd_reg == len_m1)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (put && pos_reg < LEN_W'(TEXT_SLOTS))
        begin
            store_we    = 1'b1;
            store_addr  = pos_reg[IDX_W-1:0];
            store_wdata = put_char;
            pos_next    = pos_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            res_reg      <= RES_RESET;
            byte_idx_reg <= 4'd0;
            raw_reg      <= 16'd0;
            prev_reg     <= 16'd0;
            len_reg      <= '0;
            pos_reg      <= '0;
            rd_reg       <= '0;
            tcnt_reg     <= 4'd0;
            hund_reg     <= 1'b0;
            stat_reg     <= STATUS_NEW;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_reg      <= res_next;
            byte_idx_reg <= byte_idx_next;
            raw_reg      <= raw_next;
            prev_reg     <= prev_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            rd_reg       <= rd_next;
            tcnt_reg     <= tcnt_next;
            hund_reg     <= hund_next;
            stat_reg     <= stat_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        whole_reg <= whole_next;
        frac_reg  <= frac_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
        ostat_reg <= ostat_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_addr] <= store_wdata;
    end

    assign out_valid = ovalid_reg;
    assign text_char = ochar_reg;
    assign last_char = olast_reg;
    assign status    = ostat_reg;

    a_emit_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> !store_we)
        else $error("Text store written while the text is being sent.");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && rd_reg == len_m1) |=> state_reg == S_IDLE && last_char)
        else $error("Sequencer did not return to idle after the final character.");

    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg == '0 || len_reg >= LEN_W'(4))
        else $error("Stored text length is too short to hold a reading.");

    a_crc_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        crc_ctrl.start |-> !crc_busy && byte_idx_reg < CRC_BYTE)
        else $error("CRC unit started out of sequence.");

endmodule

### verif/temp_scratchpad_to_ascii_top_tb.sv
// Self-checking testbench for the scratchpad-to-text block with a CRC and text predictor.
module temp_scratchpad_to_ascii_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 8;
    localparam int FRAMES_PER     = 6;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [1:0] st;
    } glyph_t;

    typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_NOISE} frame_kind_t;

    class text_board_t;
        logic [1:0]  res;
        logic [3:0]  byte_pos;
        logic [7:0]  crc;
        logic [15:0] raw;
        logic [15:0] last_good;
        logic [7:0]  text [TEXT_SLOTS];
        int          text_len;
        glyph_t      due [$];
        int          errors;

        function new();
            res       = RES_RESET;
            byte_pos  = 4'd0;
            crc       = 8'h00;
            raw       = 16'h0000;
            last_good = 16'h0000;
            text_len  = 0;
            errors    = 0;
            foreach (text[i]) text[i] = 8'h00;
        endfunction

        static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic [7:0] v;
            v = c ^ b;
            for (int i = 0; i < 8; i++)
                v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
            return v;
        endfunction

        function void load_res_code(logic [1:0] v);
            res = v;
        endfunction

        function int waiting();
            return due.size();
        endfunction

        function void put_char(logic [7:0] c);
            if (text_len < TEXT_SLOTS)
            begin
                text[text_len] = c;
                text_len++;
            end
        endfunction

        function void build(logic [15:0] reading);
            logic [15:0] mag;
            int          whole;
            int          frac;
            int          fbits;
            int          fmask;
            fbits    = int'(res) + 1;
            fmask    = (1 << fbits) - 1;
            mag      = reading;
            text_len = 0;
            if (reading[15])
            begin
                put_char(CHAR_MINUS);
                mag = 16'h0000 - reading;
            end
            whole = int'(mag[10:4]);
            frac  = int'(mag[3:0]) >> (4 - fbits);
            if (whole > 99)
            begin
                put_char(CHAR_ZERO + 8'(whole / 100));
                whole = whole % 100;
                put_char(CHAR_ZERO + 8'(whole / 10));
                whole = whole % 10;
            end
            else if (whole > 9)
            begin
                put_char(CHAR_ZERO + 8'(whole / 10));
                whole = whole % 10;
            end
            put_char(CHAR_ZERO + 8'(whole));
            put_char(CHAR_DOT);
            while (frac != 0)
            begin
                frac = frac * 10;
                put_char(CHAR_ZERO + 8'(frac >> fbits));
                frac = frac & fmask;
            end
            put_char(CHAR_SPACE);
            put_char(CHAR_NL);
        endfunction

        function void mark(logic [7:0] c);
            if (text_len >= 2 && text_len <= TEXT_SLOTS)
                text[text_len - 2] = c;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [1:0] st;
            if (byte_pos < CRC_BYTE)
            begin
                if (byte_pos == 4'd0)
                    raw[7:0] = b;
                else if (byte_pos == 4'd1)
                    raw[15:8] = b;
                crc = crc_step(crc, b);
                byte_pos++;
                return;
            end
            if (crc == b)
            begin
                if (raw != last_good)
                begin
                    last_good = raw;
                    build(raw);
                    st = STATUS_NEW;
                end
                else
                begin
                    mark(CHAR_SPACE);
                    st = STATUS_SAME;
                end
            end
            else
            begin
                mark(CHAR_STAR);
                st = STATUS_BAD_CRC;
            end
            byte_pos = 4'd0;
            crc      = 8'h00;
            for (int k = 0; k < text_len; k++)
                due.push_back('{ch: text[k], last: (k == text_len - 1), st: st});
        endfunction

        function void check_char(logic [7:0] ch, logic last, logic [1:0] st);
            glyph_t want;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected character: expected none, actual %h last %b status %0d",
                         $time, ch, last, st);
                return;
            end
            want = due.pop_front();
            if (want.ch !== ch)
            begin
                errors++;
                $display("%0t: text_char mismatch: expected %h, actual %h", $time, want.ch, ch);
            end
            if (want.last !== last)
            begin
                errors++;
                $display("%0t: last_char mismatch: expected %b, actual %b", $time, want.last, last);
            end
            if (want.st !== st)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.st, st);
            end
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_we       = 1'b0;
    logic [1:0] cfg_data     = 2'd0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] scratch_byte = 8'h00;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [7:0] text_char;
    logic       last_char;
    logic [1:0] status;

    text_board_t board = new();
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold = 0;

    temp_scratchpad_to_ascii_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .scratch_byte (scratch_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .text_char    (text_char),
        .last_char    (last_char),
        .status       (status)
    );

    always #5 clk = ~clk;

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic hold;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_char(text_char, last_char, status);
            if (rx_hold > 0)
            begin
                rx_hold--;
                hold = 1'b1;
            end
            else
                hold = ($urandom_range(99) < rx_stall_pct);
            out_stall <= hold;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        scratch_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_byte(b);
    endtask

    task automatic send_frame(input frame_kind_t kind, input logic [15:0] reading);
        logic [7:0] bytes [9];
        logic [7:0] c;
        c        = 8'h00;
        bytes[0] = reading[7:0];
        bytes[1] = reading[15:8];
        for (int i = 2; i < 8; i++)
            bytes[i] = 8'($urandom);
        for (int i = 0; i < 8; i++)
            c = text_board_t::crc_step(c, bytes[i]);
        bytes[8] = c;
        if (kind == FRAME_BAD_CRC)
            bytes[8] = c ^ (8'h01 << $urandom_range(7));
        else if (kind == FRAME_NOISE)
            foreach (bytes[i]) bytes[i] = 8'($urandom);
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_resolution(input logic [1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        board.load_res_code(v);
    endtask

    function automatic logic [15:0] pick_reading();
        logic [15:0] corner [13];
        int          r;
        corner = '{16'h0000, 16'h07D0, 16'hFC90, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0008,
                   16'hFFF8, 16'h0550, 16'h0191, 16'hFF5E, 16'h0001, 16'h8001};
        r = $urandom_range(99);
        if (r < 25)
            return board.last_good;
        if (r < 45)
            return corner[$urandom_range(12)];
        return 16'($urandom);
    endfunction

    task automatic random_frame();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            send_frame(FRAME_GOOD, pick_reading());
        else if (r < 85)
            send_frame(FRAME_BAD_CRC, pick_reading());
        else
            send_frame(FRAME_NOISE, 16'h0000);
    endtask

    initial
    begin
        logic [1:0] res_plan [PHASES];
        int         tx_plan [PHASES];
        int         rx_plan [PHASES];
        res_plan = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
        tx_plan  = '{0, 78, 0, 25, 0, 78, 0, 25};
        rx_plan  = '{0, 0, 78, 25, 0, 0, 78, 25};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A bad CRC and a reading equal to the reset history both come before any text.
        send_frame(FRAME_BAD_CRC, 16'h07D0);
        send_frame(FRAME_GOOD, 16'h0000);
        send_frame(FRAME_GOOD, 16'h8001);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_resolution(res_plan[p]);
            tx_idle_pct  = tx_plan[p];
            rx_stall_pct = rx_plan[p];
            if (p == 2)
                rx_hold = HOLD_CYCLES;
            for (int f = 0; f < FRAMES_PER; f++)
            begin
                if (p == 5 && f == 3)
                    settle();
                random_frame();
            end
        end

        settle();
        if (board.errors == 0 && board.waiting() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/tsa_pkg.sv
rtl/tsa_crc.sv
rtl/temp_scratchpad_to_ascii_top.sv
verif/temp_scratchpad_to_ascii_top_tb.sv
